[rtl/azs_pkg.sv]
// Shared types and constants for the allocation zone selector.
// No dependencies; imported by azs_scan and the top level.
package azs_pkg;

   // Request function codes
   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_TAKE   = 2'd1;
   localparam logic [1:0] FUNC_RETURN = 2'd2;
   localparam logic [1:0] FUNC_SELECT = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_NUM_ZONES  = 2'd0;
   localparam logic [1:0] CSR_DATA_THR   = 2'd1;
   localparam logic [1:0] CSR_HEADER_THR = 2'd2;

   // Fixed field widths
   localparam int ZONE_W   = 8;
   localparam int COUNT_W  = 11;
   localparam int NZ_CFG_W = 9;
   localparam int CSR_W    = 11;
   localparam int CSR_IDX_W = 2;

   // User count storage
   localparam int USER_W = 5;
   localparam logic [USER_W-1:0] USER_MAX = 5'd31;

   // Control from the sequencer to the scan tracker
   typedef struct packed {
      logic clear;
      logic eval;
   } scan_ctl_type;

endpackage

[rtl/azs_zone_ram.sv]
// Per-zone state memory: one write port, one read port, registered read data.
// Depends on nothing; instantiated by the top level.
module azs_zone_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 16,
   parameter int AW    = 8
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write the addressed entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read word; a write at the same edge is seen next cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/azs_scan.sv]
// Candidate tracker for the zone scan: evaluates one zone word per cycle
// and keeps the best candidates so far. Depends on azs_pkg.
module azs_scan #(
   parameter int IDXW        = 8,
   parameter int FW          = 11,
   parameter int MAX_CURSORS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  azs_pkg::scan_ctl_type          ctl,
   input  logic [azs_pkg::CSR_W-1:0]      thr,
   input  logic [IDXW-1:0]                dat_idx,
   input  logic [FW-1:0]                  dat_free,
   input  logic [azs_pkg::USER_W-1:0]     dat_user,
   output logic                           take_now,
   output logic                           found,
   output logic [IDXW-1:0]                pick_idx,
   output logic [FW-1:0]                  pick_free,
   output logic [azs_pkg::USER_W-1:0]     pick_user
);
   import azs_pkg::*;

   logic              take_ff;
   logic [IDXW-1:0]   take_idx_ff;
   logic [FW-1:0]     take_free_ff;
   logic              unused_ff;
   logic [IDXW-1:0]   unused_idx_ff;
   logic [FW-1:0]     unused_free_ff;
   logic              used_ff;
   logic [IDXW-1:0]   used_idx_ff;
   logic [FW-1:0]     used_free_ff;
   logic [USER_W-1:0] fewest_ff;
   logic              is_unused;

   assign is_unused = (dat_user == '0);
   // Unused zone above threshold ends the scan
   assign take_now  = ctl.eval && !take_ff && is_unused && (dat_free > thr);

   // Track the immediate take, the fullest unused zone and the least used zone
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         take_ff        <= 1'b0;
         unused_ff      <= 1'b0;
         used_ff        <= 1'b0;
         unused_free_ff <= '0;
         fewest_ff      <= USER_W'(MAX_CURSORS);
      end else if (ctl.eval && !take_ff) begin
         if (is_unused) begin
            if (dat_free > thr) begin
               take_ff      <= 1'b1;
               take_idx_ff  <= dat_idx;
               take_free_ff <= dat_free;
            end else if (dat_free > unused_free_ff) begin
               unused_ff      <= 1'b1;
               unused_idx_ff  <= dat_idx;
               unused_free_ff <= dat_free;
            end
         end else if ((dat_free != '0) && (dat_user < fewest_ff)) begin
            used_ff      <= 1'b1;
            used_idx_ff  <= dat_idx;
            used_free_ff <= dat_free;
            fewest_ff    <= dat_user;
         end
      end
   end

   // Choose by priority: immediate take, then unused, then used
   always_comb begin
      found     = take_ff || unused_ff || used_ff;
      pick_idx  = used_idx_ff;
      pick_free = used_free_ff;
      pick_user = fewest_ff;
      if (take_ff) begin
         pick_idx  = take_idx_ff;
         pick_free = take_free_ff;
         pick_user = '0;
      end else if (unused_ff) begin
         pick_idx  = unused_idx_ff;
         pick_free = unused_free_ff;
         pick_user = '0;
      end
   end

endmodule

[rtl/allocation_zone_selector.sv]
// Allocation zone selector top level: request sequencer, configuration
// registers and result register. Depends on azs_pkg, azs_zone_ram, azs_scan.
//
// Each zone's free count and user count share one word of a single-port-pair
// memory (one write, one registered read per cycle). After reset a clearing
// pass writes every entry, during which req_stall stays high; csr writes are
// taken throughout. A load, or a take or return to an out-of-range zone, goes
// straight to ST_FIN; a take or return passes through ST_ADJ first. A select
// reads one zone per cycle over the N effective zones, after ST_REL when it
// releases the old zone, and stops early when an unused zone above threshold
// is found. The next request is accepted while a finished word waits on rsp_.
module allocation_zone_selector #(
   parameter int MAX_AZ      = 256,
   parameter int MAX_CURSORS = 16,
   parameter int ZONE_BLOCKS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_func,
   input  logic [azs_pkg::ZONE_W-1:0]        req_zone,
   input  logic [azs_pkg::COUNT_W-1:0]       req_count,
   input  logic                              req_release_req,
   input  logic                              req_header_cursor,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_found,
   output logic [azs_pkg::ZONE_W-1:0]        rsp_chosen_zone,
   output logic [azs_pkg::COUNT_W-1:0]       rsp_chosen_free,
   output logic                              rsp_user_underflow,
   input  logic                              csr_wr_en,
   input  logic [azs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [azs_pkg::CSR_W-1:0]         csr_wdata
);
   import azs_pkg::*;

   localparam int IDXW = $clog2(MAX_AZ);
   localparam int NZW  = IDXW + 1;
   localparam int FW   = $clog2(ZONE_BLOCKS + 1);
   localparam int W    = USER_W + FW;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_ADJ, ST_REL, ST_SCAN, ST_PICK, ST_FIN
   } state_type;

   state_type         state_ff;
   logic [IDXW-1:0]   clr_idx_ff;
   logic [NZ_CFG_W-1:0] num_zones_ff;
   logic [CSR_W-1:0]  data_thr_ff;
   logic [CSR_W-1:0]  header_thr_ff;

   logic [1:0]        func_ff;
   logic [IDXW-1:0]   zone_idx_ff;
   logic              hdr_ff;
   logic [IDXW-1:0]   rd_idx_ff;
   logic [NZW-1:0]    left_ff;
   logic              pend_ff;
   logic [IDXW-1:0]   pend_idx_ff;

   logic              res_found_ff;
   logic [ZONE_W-1:0] res_zone_ff;
   logic [COUNT_W-1:0] res_free_ff;
   logic              res_uflow_ff;

   logic              rsp_valid_ff;
   logic              rsp_found_ff;
   logic [ZONE_W-1:0] rsp_zone_ff;
   logic [COUNT_W-1:0] rsp_free_ff;
   logic              rsp_uflow_ff;

   logic              accept;
   logic              zone_ok;
   logic [IDXW-1:0]   zone_idx;
   logic [NZW-1:0]    nz;
   logic [NZW-1:0]    idx_inc;
   logic [IDXW-1:0]   idx_next;
   logic [CSR_W-1:0]  thr;
   logic [FW-1:0]     load_free;

   logic              wr_en;
   logic [IDXW-1:0]   wr_addr;
   logic [W-1:0]      wr_data;
   logic              rd_en;
   logic [IDXW-1:0]   rd_addr;
   logic [W-1:0]      rd_data;
   logic [FW-1:0]     rd_free;
   logic [USER_W-1:0] rd_user;

   scan_ctl_type      scan_ctl;
   logic              take_now;
   logic              found;
   logic [IDXW-1:0]   pick_idx;
   logic [FW-1:0]     pick_free;
   logic [USER_W-1:0] pick_user;
   logic [USER_W-1:0] pick_user_inc;

   // Decode the request and the effective zone count
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign zone_ok   = (req_zone < MAX_AZ);
   assign zone_idx  = IDXW'(req_zone);
   assign load_free = (req_count > ZONE_BLOCKS) ? FW'(ZONE_BLOCKS) : FW'(req_count);
   assign thr       = hdr_ff ? header_thr_ff : data_thr_ff;
   assign rd_free   = rd_data[FW-1:0];
   assign rd_user   = rd_data[W-1:FW];

   always_comb begin
      if (num_zones_ff == '0) begin
         nz = NZW'(1);
      end else if (num_zones_ff > MAX_AZ) begin
         nz = NZW'(MAX_AZ);
      end else begin
         nz = NZW'(num_zones_ff);
      end
   end

   // Circular scan address
   assign idx_inc  = {1'b0, rd_idx_ff} + NZW'(1);
   assign idx_next = (idx_inc >= nz) ? '0 : idx_inc[IDXW-1:0];

   assign pick_user_inc = (pick_user < USER_MAX) ? pick_user + USER_W'(1) : pick_user;

   // Memory ports
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = zone_idx_ff;
      wr_data = rd_data;
      rd_en   = 1'b0;
      rd_addr = rd_idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_ff;
            wr_data = '0;
         end
         ST_IDLE: begin
            rd_en   = accept;
            rd_addr = zone_idx;
            wr_en   = accept && zone_ok && (req_func == FUNC_LOAD);
            wr_addr = zone_idx;
            wr_data = {{USER_W{1'b0}}, load_free};
         end
         ST_ADJ: begin
            wr_en = 1'b1;
            if (func_ff == FUNC_TAKE) begin
               wr_data = {rd_user, (rd_free != '0) ? rd_free - FW'(1) : rd_free};
            end else begin
               wr_data = {rd_user,
                          (rd_free < FW'(ZONE_BLOCKS)) ? rd_free + FW'(1) : rd_free};
            end
         end
         ST_REL: begin
            wr_en   = (rd_user != '0);
            wr_data = {rd_user - USER_W'(1), rd_free};
         end
         ST_SCAN: begin
            rd_en = (left_ff != '0);
         end
         ST_PICK: begin
            wr_en   = found;
            wr_addr = pick_idx;
            wr_data = {pick_user_inc, pick_free};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   assign scan_ctl.clear = (state_ff == ST_IDLE) || (state_ff == ST_REL);
   assign scan_ctl.eval  = (state_ff == ST_SCAN) && pend_ff;

   azs_zone_ram #(
      .DEPTH (MAX_AZ),
      .WIDTH (W),
      .AW    (IDXW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   azs_scan #(
      .IDXW        (IDXW),
      .FW          (FW),
      .MAX_CURSORS (MAX_CURSORS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .thr       (thr),
      .dat_idx   (pend_idx_ff),
      .dat_free  (rd_free),
      .dat_user  (rd_user),
      .take_now  (take_now),
      .found     (found),
      .pick_idx  (pick_idx),
      .pick_free (pick_free),
      .pick_user (pick_user)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_zones_ff  <= NZ_CFG_W'(1);
         data_thr_ff   <= '0;
         header_thr_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_NUM_ZONES:  num_zones_ff  <= csr_wdata[NZ_CFG_W-1:0];
            CSR_DATA_THR:   data_thr_ff   <= csr_wdata;
            CSR_HEADER_THR: header_thr_ff <= csr_wdata;
            default:        num_zones_ff  <= num_zones_ff;
         endcase
      end
   end

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         pend_ff      <= 1'b0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the result word once taken
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + IDXW'(1);
               if (clr_idx_ff == IDXW'(MAX_AZ - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  func_ff      <= req_func;
                  zone_idx_ff  <= zone_idx;
                  hdr_ff       <= req_header_cursor;
                  rd_idx_ff    <= (req_zone < nz) ? zone_idx : '0;
                  left_ff      <= nz;
                  pend_ff      <= 1'b0;
                  res_found_ff <= 1'b0;
                  res_zone_ff  <= '0;
                  res_free_ff  <= '0;
                  res_uflow_ff <= 1'b0;
                  if (req_func == FUNC_SELECT) begin
                     state_ff <= (req_release_req && zone_ok) ? ST_REL : ST_SCAN;
                  end else if (zone_ok && (req_func != FUNC_LOAD)) begin
                     state_ff <= ST_ADJ;
                  end else begin
                     state_ff <= ST_FIN;
                  end
               end
            end
            ST_ADJ: begin
               state_ff <= ST_FIN;
            end
            ST_REL: begin
               res_uflow_ff <= (rd_user == '0);
               state_ff     <= ST_SCAN;
            end
            ST_SCAN: begin
               // Issue one read per cycle, evaluate the word read last cycle
               if (left_ff != '0) begin
                  rd_idx_ff   <= idx_next;
                  left_ff     <= left_ff - NZW'(1);
                  pend_ff     <= 1'b1;
                  pend_idx_ff <= rd_idx_ff;
               end else begin
                  pend_ff <= 1'b0;
               end
               if (pend_ff && (take_now || (left_ff == '0))) begin
                  state_ff <= ST_PICK;
               end
            end
            ST_PICK: begin
               if (found) begin
                  res_found_ff <= 1'b1;
                  res_zone_ff  <= ZONE_W'(pick_idx);
                  res_free_ff  <= COUNT_W'(pick_free);
               end
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               // Hold until the output register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_found_ff <= res_found_ff;
                  rsp_zone_ff  <= res_zone_ff;
                  rsp_free_ff  <= res_free_ff;
                  rsp_uflow_ff <= res_uflow_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_chosen_zone    = rsp_zone_ff;
   assign rsp_chosen_free    = rsp_free_ff;
   assign rsp_user_underflow = rsp_uflow_ff;

endmodule
